/* rtl/rcfs_pkg.sv */
// Shared types, constants and a helper function for the rectangle corner generator.
`default_nettype none

package rcfs_pkg;

   localparam int unsigned SQ_STEPS   = 32;
   localparam int unsigned DIV_STEPS  = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned NORM_MSB   = 29;

   localparam logic        CSR_IDX_EPSILON = 1'b0;
   localparam logic [15:0] EPSILON_RESET   = 16'd1;
   localparam logic [1:0]  ITEM_GAP        = 2'd3;
   localparam logic [1:0]  CORNER_LAST     = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_COINCIDE = 2'd1,
      STATUS_SMALL    = 2'd2,
      STATUS_VERTICAL = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] from_z;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
      logic signed [31:0] to_z;
      logic [30:0]        rect_width;
      logic [30:0]        rect_length;
   } req_type;

   typedef struct packed {
      logic [1:0]         corner_index;
      logic signed [31:0] corner_x;
      logic signed [31:0] corner_y;
      logic signed [31:0] corner_z;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   // One finished rectangle, handed to the corner sequencer.
   typedef struct packed {
      logic signed [31:0] c_x;
      logic signed [31:0] c_y;
      logic signed [31:0] c_z;
      logic signed [31:0] u_x;
      logic signed [31:0] u_y;
      logic signed [31:0] u_z;
      logic signed [31:0] p_x;
      logic signed [31:0] p_y;
      logic               first;
      status_type         status;
   } item_type;

   // c +/- u +/- p with saturation to 32 bits
   function automatic logic signed [31:0] corner_coord(input logic signed [31:0] c,
                                                        input logic signed [31:0] u,
                                                        input logic signed [31:0] p,
                                                        input logic neg_u,
                                                        input logic neg_p);
      logic signed [33:0] cw;
      logic signed [33:0] uw;
      logic signed [33:0] pw;
      logic signed [33:0] sum;
      cw  = 34'(c);
      uw  = neg_u ? -34'(u) : 34'(u);
      pw  = neg_p ? -34'(p) : 34'(p);
      sum = cw + uw + pw;
      if ((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111)) begin
         return sum[31:0];
      end else if (sum[33]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/rcfs_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module rcfs_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_vld,
   input  logic [63:0] in_val,
   output logic        out_vld,
   output logic [31:0] out_root
);
   import rcfs_pkg::*;

   logic [63:0] v_ff   [SQ_STEPS];
   logic [63:0] r_ff   [SQ_STEPS];
   logic        vld_ff [SQ_STEPS];

   for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
      localparam logic [63:0] BIT = 64'(1) << (2 * (SQ_STEPS - 1 - s));
      logic [63:0] v_src;
      logic [63:0] r_src;
      logic        vld_src;
      logic [63:0] trial;
      logic [63:0] v_in;
      logic [63:0] r_in;

      if (s == 0) begin : g_first
         assign v_src   = in_val;
         assign r_src   = '0;
         assign vld_src = in_vld;
      end else begin : g_next
         assign v_src   = v_ff[s-1];
         assign r_src   = r_ff[s-1];
         assign vld_src = vld_ff[s-1];
      end

      always_comb begin
         trial = r_src + BIT;
         if (v_src >= trial) begin
            v_in = v_src - trial;
            r_in = (r_src >> 1) + BIT;
         end else begin
            v_in = v_src;
            r_in = r_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
         v_ff[s] <= v_in;
         r_ff[s] <= r_in;
      end
   end

   assign out_vld  = vld_ff[SQ_STEPS-1];
   assign out_root = r_ff[SQ_STEPS-1][31:0];

endmodule

`default_nettype wire

/* rtl/rcfs_div.sv */
// Pipelined restoring divider, 64 by 32 bits, one quotient bit per stage.
`default_nettype none

module rcfs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_vld,
   input  logic [63:0] in_num,
   input  logic [31:0] in_den,
   output logic        out_vld,
   output logic [31:0] out_quo
);
   import rcfs_pkg::*;

   logic [31:0] rem_ff [DIV_STEPS];
   logic [31:0] lo_ff  [DIV_STEPS];
   logic [31:0] quo_ff [DIV_STEPS];
   logic [31:0] den_ff [DIV_STEPS];
   logic        vld_ff [DIV_STEPS];

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [31:0] rem_src;
      logic [31:0] lo_src;
      logic [31:0] quo_src;
      logic [31:0] den_src;
      logic        vld_src;
      logic [32:0] trial;
      logic [31:0] rem_in;
      logic        bit_in;

      if (s == 0) begin : g_first
         // quotient fits 32 bits, so the upper half is already below the divisor
         assign rem_src = in_num[63:32];
         assign lo_src  = in_num[31:0];
         assign quo_src = '0;
         assign den_src = in_den;
         assign vld_src = in_vld;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign lo_src  = lo_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign den_src = den_ff[s-1];
         assign vld_src = vld_ff[s-1];
      end

      always_comb begin
         trial = {rem_src, lo_src[31]};
         if (trial >= {1'b0, den_src}) begin
            rem_in = 32'(trial - {1'b0, den_src});
            bit_in = 1'b1;
         end else begin
            rem_in = trial[31:0];
            bit_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
         rem_ff[s] <= rem_in;
         lo_ff[s]  <= {lo_src[30:0], 1'b0};
         quo_ff[s] <= {quo_src[30:0], bit_in};
         den_ff[s] <= den_src;
      end
   end

   assign out_vld = vld_ff[DIV_STEPS-1];
   assign out_quo = quo_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

/* rtl/rcfs_emit.sv */
// Corner sequencer: turns one finished rectangle into its result transactions.
`default_nettype none

module rcfs_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_vld,
   input  rcfs_pkg::item_type item,
   output logic              rsp_valid,
   output rcfs_pkg::rsp_type rsp_data
);
   import rcfs_pkg::*;

   item_type   hold_ff, hold_in;
   logic       active_ff, active_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       neg_u;
   logic       neg_p;
   logic       outer;

   always_comb begin
      hold_in      = hold_ff;
      active_in    = active_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      neg_u        = (cnt_ff < 2'd2);
      outer        = (cnt_ff == 2'd0) || (cnt_ff == CORNER_LAST);
      neg_p        = hold_ff.first ? outer : !outer;

      if (active_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in.status = hold_ff.status;
         if (hold_ff.status != STATUS_OK) begin
            rsp_in.corner_index = 2'd0;
            rsp_in.corner_x     = '0;
            rsp_in.corner_y     = '0;
            rsp_in.corner_z     = '0;
            rsp_in.last         = 1'b1;
            active_in           = 1'b0;
         end else begin
            rsp_in.corner_index = cnt_ff;
            rsp_in.corner_x = corner_coord(hold_ff.c_x, hold_ff.u_x, hold_ff.p_x, neg_u, neg_p);
            rsp_in.corner_y = corner_coord(hold_ff.c_y, hold_ff.u_y, hold_ff.p_y, neg_u, neg_p);
            rsp_in.corner_z = corner_coord(hold_ff.c_z, hold_ff.u_z, '0, neg_u, neg_p);
            rsp_in.last     = (cnt_ff == CORNER_LAST);
            cnt_in          = cnt_ff + 2'd1;
            if (cnt_ff == CORNER_LAST) begin
               active_in = 1'b0;
            end
         end
      end

      // busy spaces the items so that the last corner of the previous item is out by now
      if (item_vld) begin
         hold_in   = item;
         active_in = 1'b1;
         cnt_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/rectangle_corners_from_segment_core.sv */
// Result: the four corners leave on consecutive cycles; an error result is a
// single one. Requests are spaced by busy, raised after each accept, so that
// the four corners can share the single result port.
// Reset: synchronous, clears all valid bits and sets epsilon to 1.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module rectangle_corners_from_segment_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rcfs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output rcfs_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rcfs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import rcfs_pkg::*;

   typedef struct packed {
      logic [31:0]        m_x, m_y, m_z;
      logic               neg_x, neg_y, neg_z;
      logic signed [31:0] c_x, c_y, c_z;
      logic [30:0]        w, len;
   } s1_type;

   typedef struct packed {
      logic               zero3, small3, size_err, hz, dypos;
      logic [31:0]        sq_x, sq_y, sq_z;
      logic [31:0]        mx3, mxh;
      logic [31:0]        m_x, m_y, m_z;
      logic               neg_x, neg_y, neg_z;
      logic signed [31:0] c_x, c_y, c_z;
      logic [30:0]        w, len;
   } s2_type;

   typedef struct packed {
      status_type         err;
      logic [4:0]         pos3, posh;
      logic               hz, dypos;
      logic [31:0]        m_x, m_y, m_z;
      logic               neg_x, neg_y, neg_z;
      logic signed [31:0] c_x, c_y, c_z;
      logic [30:0]        w, len;
   } s3_type;

   typedef struct packed {
      status_type         err;
      logic               hz, dypos;
      logic [29:0]        a_x, a_y, a_z, b_x, b_y;
      logic               neg_x, neg_y, neg_z;
      logic signed [31:0] c_x, c_y, c_z;
      logic [30:0]        w, len;
   } s4_type;

   // geometry that rides along with the divisions
   typedef struct packed {
      status_type         err;
      logic               hz, dypos;
      logic               neg_x, neg_y, neg_z;
      logic signed [31:0] c_x, c_y, c_z;
   } side_b_type;

   typedef struct packed {
      logic [60:0] pu_x, pu_y, pu_z, pkx, pky;
      side_b_type  geo;
   } side_a_type;

   typedef struct packed {
      logic [59:0] sqa_x, sqa_y, sqa_z, sqb_x, sqb_y;
      side_a_type  side;
   } s5_type;

   typedef struct packed {
      logic [63:0] v3, vh;
      side_a_type  side;
   } s6_type;

   typedef struct packed {
      logic [63:0] num_x, num_y, num_z, num_kx, num_ky;
      logic [31:0] den_u, den_p;
   } s7_type;

   typedef struct packed {
      logic signed [31:0] c_x, c_y, c_z, u_x, u_y, u_z, p_x, p_y;
      status_type         status;
   } s8_type;

   typedef struct packed {
      logic signed [63:0] prod_a, prod_b;
      s8_type             base;
   } s9_type;

   function automatic logic [4:0] msb_pos(input logic [31:0] v);
      logic [4:0] pos;
      pos = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) pos = 5'(i);
      end
      return pos;
   endfunction

   // bring the largest magnitude into [2^29, 2^30)
   function automatic logic [29:0] norm_mag(input logic [31:0] m, input logic [4:0] pos);
      logic [31:0] t;
      if (pos >= 5'(NORM_MSB)) begin
         t = m >> (pos - 5'(NORM_MSB));
      end else begin
         t = m << (5'(NORM_MSB) - pos);
      end
      return t[29:0];
   endfunction

   logic [15:0] eps_ff, eps_in;
   logic [1:0]  gap_ff, gap_in;
   logic        accept;
   logic        csr_write;

   logic [5:0]  front_vld_ff, front_vld_in;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   s5_type      s5_ff, s5_in;
   s6_type      s6_ff, s6_in;

   logic        sq3_vld, sqh_vld;
   logic [31:0] l2, h2;
   side_a_type  side_a_ff [SQ_STEPS];

   logic        s7_vld_ff, s7_vld_in;
   s7_type      s7_ff, s7_in;
   side_b_type  side_b_ff [DIV_STEPS];
   side_b_type  s7_side_ff;

   logic [4:0]  div_vld;
   logic [31:0] mag_x, mag_y, mag_z, kx, ky;

   logic [2:0]  back_vld_ff, back_vld_in;
   s8_type      s8_ff, s8_in;
   s9_type      s9_ff, s9_in;
   item_type    s10_ff, s10_in;

   // ---------------- control and CSR ----------------
   assign accept    = start && !busy;
   assign busy      = (gap_ff != 2'd0);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_IDX_EPSILON) ? {16'd0, eps_ff} : 32'd0;

   always_comb begin
      eps_in = eps_ff;
      if (csr_write && (paddr[2] == CSR_IDX_EPSILON)) begin
         eps_in = pwdata[15:0];
      end
      gap_in = gap_ff;
      if (accept) begin
         gap_in = ITEM_GAP;
      end else if (gap_ff != 2'd0) begin
         gap_in = gap_ff - 2'd1;
      end
   end

   // ---------------- front stages ----------------
   always_comb begin
      logic signed [32:0] dx, dy, dz, sx, sy, sz;
      logic [33:0]        sqsum;
      dx = 33'(req_data.to_x) - 33'(req_data.from_x);
      dy = 33'(req_data.to_y) - 33'(req_data.from_y);
      dz = 33'(req_data.to_z) - 33'(req_data.from_z);
      sx = 33'(req_data.to_x) + 33'(req_data.from_x);
      sy = 33'(req_data.to_y) + 33'(req_data.from_y);
      sz = 33'(req_data.to_z) + 33'(req_data.from_z);

      s1_in.neg_x = dx[32];
      s1_in.neg_y = dy[32];
      s1_in.neg_z = dz[32];
      s1_in.m_x   = dx[32] ? 32'(-dx) : dx[31:0];
      s1_in.m_y   = dy[32] ? 32'(-dy) : dy[31:0];
      s1_in.m_z   = dz[32] ? 32'(-dz) : dz[31:0];
      // dropping the low bit of the sum floors the halving
      s1_in.c_x   = sx[32:1];
      s1_in.c_y   = sy[32:1];
      s1_in.c_z   = sz[32:1];
      s1_in.w     = req_data.rect_width;
      s1_in.len   = req_data.rect_length;

      s2_in.zero3    = (s1_ff.m_x == '0) && (s1_ff.m_y == '0) && (s1_ff.m_z == '0);
      s2_in.small3   = (s1_ff.m_x < 32'(eps_ff)) && (s1_ff.m_y < 32'(eps_ff))
                       && (s1_ff.m_z < 32'(eps_ff));
      s2_in.size_err = (s1_ff.w < 31'(eps_ff)) || (s1_ff.len < 31'(eps_ff));
      s2_in.hz       = (s1_ff.m_x == '0) && (s1_ff.m_y == '0);
      s2_in.dypos    = !s1_ff.neg_y && (s1_ff.m_y != '0);
      s2_in.sq_x     = 32'(s1_ff.m_x[15:0]) * 32'(s1_ff.m_x[15:0]);
      s2_in.sq_y     = 32'(s1_ff.m_y[15:0]) * 32'(s1_ff.m_y[15:0]);
      s2_in.sq_z     = 32'(s1_ff.m_z[15:0]) * 32'(s1_ff.m_z[15:0]);
      s2_in.mxh      = (s1_ff.m_x > s1_ff.m_y) ? s1_ff.m_x : s1_ff.m_y;
      s2_in.mx3      = (s2_in.mxh > s1_ff.m_z) ? s2_in.mxh : s1_ff.m_z;
      s2_in.m_x      = s1_ff.m_x;
      s2_in.m_y      = s1_ff.m_y;
      s2_in.m_z      = s1_ff.m_z;
      s2_in.neg_x    = s1_ff.neg_x;
      s2_in.neg_y    = s1_ff.neg_y;
      s2_in.neg_z    = s1_ff.neg_z;
      s2_in.c_x      = s1_ff.c_x;
      s2_in.c_y      = s1_ff.c_y;
      s2_in.c_z      = s1_ff.c_z;
      s2_in.w        = s1_ff.w;
      s2_in.len      = s1_ff.len;

      sqsum = 34'(s2_ff.sq_x) + 34'(s2_ff.sq_y) + 34'(s2_ff.sq_z);
      if (s2_ff.zero3) begin
         s3_in.err = STATUS_COINCIDE;
      end else if (s2_ff.small3 && (sqsum < 34'(32'(eps_ff) * 32'(eps_ff)))) begin
         s3_in.err = STATUS_COINCIDE;
      end else if (s2_ff.size_err) begin
         s3_in.err = STATUS_SMALL;
      end else begin
         s3_in.err = STATUS_OK;
      end
      s3_in.pos3  = msb_pos(s2_ff.mx3);
      s3_in.posh  = msb_pos(s2_ff.mxh);
      s3_in.hz    = s2_ff.hz;
      s3_in.dypos = s2_ff.dypos;
      s3_in.m_x   = s2_ff.m_x;
      s3_in.m_y   = s2_ff.m_y;
      s3_in.m_z   = s2_ff.m_z;
      s3_in.neg_x = s2_ff.neg_x;
      s3_in.neg_y = s2_ff.neg_y;
      s3_in.neg_z = s2_ff.neg_z;
      s3_in.c_x   = s2_ff.c_x;
      s3_in.c_y   = s2_ff.c_y;
      s3_in.c_z   = s2_ff.c_z;
      s3_in.w     = s2_ff.w;
      s3_in.len   = s2_ff.len;

      s4_in.err   = s3_ff.err;
      s4_in.hz    = s3_ff.hz;
      s4_in.dypos = s3_ff.dypos;
      s4_in.a_x   = norm_mag(s3_ff.m_x, s3_ff.pos3);
      s4_in.a_y   = norm_mag(s3_ff.m_y, s3_ff.pos3);
      s4_in.a_z   = norm_mag(s3_ff.m_z, s3_ff.pos3);
      s4_in.b_x   = norm_mag(s3_ff.m_x, s3_ff.posh);
      s4_in.b_y   = norm_mag(s3_ff.m_y, s3_ff.posh);
      s4_in.neg_x = s3_ff.neg_x;
      s4_in.neg_y = s3_ff.neg_y;
      s4_in.neg_z = s3_ff.neg_z;
      s4_in.c_x   = s3_ff.c_x;
      s4_in.c_y   = s3_ff.c_y;
      s4_in.c_z   = s3_ff.c_z;
      s4_in.w     = s3_ff.w;
      s4_in.len   = s3_ff.len;

      s5_in.sqa_x          = 60'(s4_ff.a_x) * 60'(s4_ff.a_x);
      s5_in.sqa_y          = 60'(s4_ff.a_y) * 60'(s4_ff.a_y);
      s5_in.sqa_z          = 60'(s4_ff.a_z) * 60'(s4_ff.a_z);
      s5_in.sqb_x          = 60'(s4_ff.b_x) * 60'(s4_ff.b_x);
      s5_in.sqb_y          = 60'(s4_ff.b_y) * 60'(s4_ff.b_y);
      s5_in.side.pu_x      = 61'(s4_ff.a_x) * 61'(s4_ff.len);
      s5_in.side.pu_y      = 61'(s4_ff.a_y) * 61'(s4_ff.len);
      s5_in.side.pu_z      = 61'(s4_ff.a_z) * 61'(s4_ff.len);
      s5_in.side.pkx       = 61'(s4_ff.b_y) * 61'(s4_ff.w);
      s5_in.side.pky       = 61'(s4_ff.b_x) * 61'(s4_ff.w);
      s5_in.side.geo.err   = s4_ff.err;
      s5_in.side.geo.hz    = s4_ff.hz;
      s5_in.side.geo.dypos = s4_ff.dypos;
      s5_in.side.geo.neg_x = s4_ff.neg_x;
      s5_in.side.geo.neg_y = s4_ff.neg_y;
      s5_in.side.geo.neg_z = s4_ff.neg_z;
      s5_in.side.geo.c_x   = s4_ff.c_x;
      s5_in.side.geo.c_y   = s4_ff.c_y;
      s5_in.side.geo.c_z   = s4_ff.c_z;

      // 4 * sum of squares, fed to the square roots
      s6_in.v3   = (64'(s5_ff.sqa_x) + 64'(s5_ff.sqa_y) + 64'(s5_ff.sqa_z)) << 2;
      s6_in.vh   = (64'(s5_ff.sqb_x) + 64'(s5_ff.sqb_y)) << 2;
      s6_in.side = s5_ff.side;

      front_vld_in = {front_vld_ff[4:0], accept};
   end

   // ---------------- square roots ----------------
   rcfs_isqrt u_sqrt_3d (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (front_vld_ff[5]),
      .in_val   (s6_ff.v3),
      .out_vld  (sq3_vld),
      .out_root (l2)
   );

   rcfs_isqrt u_sqrt_h (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (front_vld_ff[5]),
      .in_val   (s6_ff.vh),
      .out_vld  (sqh_vld),
      .out_root (h2)
   );

   // rounding numerators: product + divisor/2
   always_comb begin
      s7_vld_in    = sq3_vld && sqh_vld;
      s7_in.num_x  = 64'(side_a_ff[SQ_STEPS-1].pu_x) + 64'(l2 >> 1);
      s7_in.num_y  = 64'(side_a_ff[SQ_STEPS-1].pu_y) + 64'(l2 >> 1);
      s7_in.num_z  = 64'(side_a_ff[SQ_STEPS-1].pu_z) + 64'(l2 >> 1);
      s7_in.num_kx = 64'(side_a_ff[SQ_STEPS-1].pkx) + 64'(h2 >> 1);
      s7_in.num_ky = 64'(side_a_ff[SQ_STEPS-1].pky) + 64'(h2 >> 1);
      s7_in.den_u  = l2;
      s7_in.den_p  = h2;
   end

   // ---------------- divisions ----------------
   rcfs_div u_div_ux (
      .clock (clock), .reset (reset), .in_vld (s7_vld_ff),
      .in_num (s7_ff.num_x), .in_den (s7_ff.den_u),
      .out_vld (div_vld[0]), .out_quo (mag_x)
   );

   rcfs_div u_div_uy (
      .clock (clock), .reset (reset), .in_vld (s7_vld_ff),
      .in_num (s7_ff.num_y), .in_den (s7_ff.den_u),
      .out_vld (div_vld[1]), .out_quo (mag_y)
   );

   rcfs_div u_div_uz (
      .clock (clock), .reset (reset), .in_vld (s7_vld_ff),
      .in_num (s7_ff.num_z), .in_den (s7_ff.den_u),
      .out_vld (div_vld[2]), .out_quo (mag_z)
   );

   rcfs_div u_div_kx (
      .clock (clock), .reset (reset), .in_vld (s7_vld_ff),
      .in_num (s7_ff.num_kx), .in_den (s7_ff.den_p),
      .out_vld (div_vld[3]), .out_quo (kx)
   );

   rcfs_div u_div_ky (
      .clock (clock), .reset (reset), .in_vld (s7_vld_ff),
      .in_num (s7_ff.num_ky), .in_den (s7_ff.den_p),
      .out_vld (div_vld[4]), .out_quo (ky)
   );

   // ---------------- back stages ----------------
   always_comb begin
      side_b_type g;
      logic       near_x, near_y, vert, sneg, pxneg, pyneg;
      logic signed [63:0] cz;
      g = side_b_ff[DIV_STEPS-1];

      near_x = {mag_x, 1'b0} < 33'(eps_ff);
      near_y = {mag_y, 1'b0} < 33'(eps_ff);
      vert   = g.hz || (near_x && near_y);
      // sign choice: p.y >= 0 normally, p.x >= 0 when the axis is nearly along y
      sneg   = near_x ? g.dypos : g.neg_x;
      pxneg  = sneg ^ !g.neg_y;
      pyneg  = sneg ^ g.neg_x;

      s8_in.c_x = g.c_x;
      s8_in.c_y = g.c_y;
      s8_in.c_z = g.c_z;
      s8_in.u_x = g.neg_x ? -mag_x : mag_x;
      s8_in.u_y = g.neg_y ? -mag_y : mag_y;
      s8_in.u_z = g.neg_z ? -mag_z : mag_z;
      s8_in.p_x = pxneg ? -kx : kx;
      s8_in.p_y = pyneg ? -ky : ky;
      if (g.err != STATUS_OK) begin
         s8_in.status = g.err;
      end else if (vert) begin
         s8_in.status = STATUS_VERTICAL;
      end else begin
         s8_in.status = STATUS_OK;
      end

      s9_in.prod_a = 64'(s8_ff.u_x) * 64'(s8_ff.p_y);
      s9_in.prod_b = 64'(s8_ff.u_y) * 64'(s8_ff.p_x);
      s9_in.base   = s8_ff;

      cz            = s9_ff.prod_a - s9_ff.prod_b;
      s10_in.c_x    = s9_ff.base.c_x;
      s10_in.c_y    = s9_ff.base.c_y;
      s10_in.c_z    = s9_ff.base.c_z;
      s10_in.u_x    = s9_ff.base.u_x;
      s10_in.u_y    = s9_ff.base.u_y;
      s10_in.u_z    = s9_ff.base.u_z;
      s10_in.p_x    = s9_ff.base.p_x;
      s10_in.p_y    = s9_ff.base.p_y;
      s10_in.status = s9_ff.base.status;
      s10_in.first  = cz[63] || (cz == '0);

      back_vld_in = {back_vld_ff[1:0], &div_vld};
   end

   rcfs_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .item_vld  (back_vld_ff[2]),
      .item      (s10_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= EPSILON_RESET;
         gap_ff       <= 2'd0;
         front_vld_ff <= '0;
         s7_vld_ff    <= 1'b0;
         back_vld_ff  <= '0;
      end else begin
         eps_ff       <= eps_in;
         gap_ff       <= gap_in;
         front_vld_ff <= front_vld_in;
         s7_vld_ff    <= s7_vld_in;
         back_vld_ff  <= back_vld_in;
      end
      s1_ff      <= s1_in;
      s2_ff      <= s2_in;
      s3_ff      <= s3_in;
      s4_ff      <= s4_in;
      s5_ff      <= s5_in;
      s6_ff      <= s6_in;
      s7_ff      <= s7_in;
      s7_side_ff <= side_a_ff[SQ_STEPS-1].geo;
      s8_ff      <= s8_in;
      s9_ff      <= s9_in;
      s10_ff     <= s10_in;

      side_a_ff[0] <= s6_ff.side;
      for (int i = 1; i < SQ_STEPS; i++) begin
         side_a_ff[i] <= side_a_ff[i-1];
      end
      side_b_ff[0] <= s7_side_ff;
      for (int i = 1; i < DIV_STEPS; i++) begin
         side_b_ff[i] <= side_b_ff[i-1];
      end
   end

   // ---------------- assertions ----------------
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an accepted transaction");

   a_error_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.last
                                                      && (rsp_data.corner_index == 2'd0))
      else $error("error result is not a single final transaction");

   a_corners_consecutive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid
         && (rsp_data.corner_index == 2'($past(rsp_data.corner_index) + 2'd1)))
      else $error("corner sequence broken");

   a_last_corner : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last && (rsp_data.status == STATUS_OK)
         |-> (rsp_data.corner_index == CORNER_LAST))
      else $error("last flag on wrong corner");

endmodule

`default_nettype wire
